FILE: src/fba_pkg.sv
// Shared types and constants for the block allocator.
// No dependencies; every other file in src takes from it by scoped names.
`default_nettype none

package fba_pkg;

    localparam int NUM_BLOCKS_DEF = 32768;
    // 15-bit block fields reach no further than this
    localparam int MAX_BLOCKS     = 32768;
    localparam int WORD_BITS      = 32;
    localparam int CFG_W          = 16;

    localparam logic [CFG_W-1:0] RESERVED_RESET = 16'd90;
    localparam logic [15:0]      END_MARK       = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_FORMAT = 2'd0,
        KIND_ALLOC  = 2'd1,
        KIND_FREE   = 2'd2,
        KIND_READ   = 2'd3
    } fba_kind_t;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_RD_DATA,
        ST_FREE_WR,
        ST_AL_FIRST,
        ST_AL_SUMSCAN,
        ST_AL_TOPSCAN,
        ST_AL_SUMRD,
        ST_AL_WORD,
        ST_AL_GRANT,
        ST_AL_LINKRD,
        ST_AL_LINKWR
    } fba_state_t;

    typedef struct packed {
        fba_kind_t   kind;
        logic [14:0] block_index;
        logic [14:0] prev_block;
        logic        has_prev;
    } fba_req_t;

    typedef struct packed {
        logic               status;
        logic [14:0]        granted_block;
        logic signed [15:0] next_entry;
    } fba_rsp_t;

    typedef struct packed {
        logic busy;
        logic done;
    } fba_stat_t;

endpackage

`default_nettype wire

FILE: src/fba_find.sv
// Shared search unit: lowest set bit of a 32-bit word at or above a start position.
// Depends on fba_pkg.
`default_nettype none

module fba_find (
    input  wire logic [fba_pkg::WORD_BITS-1:0] vec,
    input  wire logic [5:0]                    from,
    output logic                               found,
    output logic [4:0]                         idx
);

    logic [fba_pkg::WORD_BITS-1:0] masked;

    always_comb
    begin
        // a start of 32 or more leaves nothing to find
        masked = from[5] ? '0 : (vec & ({fba_pkg::WORD_BITS{1'b1}} << from[4:0]));
        found  = |masked;
        idx    = 5'd0;
        for (int i = fba_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                idx = 5'(i);
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/fba_core.sv
// Request sequencer with the free bitmap, summary and next-table memories.
// Depends on fba_pkg and fba_find.
`default_nettype none

module fba_core #(
    parameter int NUM_BLOCKS = fba_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire fba_pkg::fba_req_t        req,
    input  wire logic [fba_pkg::CFG_W-1:0] reserved,
    output fba_pkg::fba_stat_t            stat,
    output fba_pkg::fba_rsp_t             rsp
);

    localparam int BLK_COUNT = (NUM_BLOCKS < fba_pkg::MAX_BLOCKS) ?
                               NUM_BLOCKS : fba_pkg::MAX_BLOCKS;
    localparam int NW        = (BLK_COUNT + 31) / 32;
    localparam int WIW       = $clog2(NW);
    localparam int NS        = (NW + 31) / 32;
    localparam int SIW       = (NS > 1) ? $clog2(NS) : 1;
    localparam int IW        = $clog2(BLK_COUNT);
    localparam int LAST_BITS = BLK_COUNT - (NW - 1) * 32;
    localparam logic [31:0] LAST_MASK = (LAST_BITS >= 32) ? 32'hFFFF_FFFF :
                                        ((32'd1 << LAST_BITS) - 32'd1);
    localparam logic [WIW-1:0] LAST_W = WIW'(NW - 1);
    localparam logic [15:0] LIM_RESET = (32'(fba_pkg::RESERVED_RESET) < BLK_COUNT) ?
                                        fba_pkg::RESERVED_RESET : 16'(BLK_COUNT);

    // bitmap entry: fresh flags in the upper half, free flags in the lower half
    logic [63:0]  bm_mem [NW];
    logic [31:0]  sm_mem [NS];
    logic [15:0]  nt_mem [BLK_COUNT];

    logic           bm_we, sm_we, nt_we;
    logic [WIW-1:0] bm_wa, bm_ra;
    logic [63:0]    bm_wd;
    logic [SIW-1:0] sm_wa, sm_ra;
    logic [31:0]    sm_wd;
    logic [IW-1:0]  nt_wa, nt_ra;
    logic [15:0]    nt_wd;
    logic [63:0]    bm_rd_reg;
    logic [31:0]    sm_rd_reg;
    logic [15:0]    nt_rd_reg;

    fba_pkg::fba_state_t state_reg, state_next;
    logic [WIW-1:0]      cnt_reg, cnt_next;
    logic [31:0]         acc_reg, acc_next;
    logic [15:0]         fmt_lim_reg, fmt_lim_next;
    logic                fmt_req_reg, fmt_req_next;
    fba_pkg::fba_req_t   req_reg, req_next;
    logic [WIW-1:0]      cur_w_reg, cur_w_next;
    logic [4:0]          gb_reg, gb_next;
    logic [63:0]         word_reg, word_next;
    logic [31:0]         sum_reg, sum_next;
    logic [NS-1:0]       top_reg, top_next;

    logic [31:0]    f_vec;
    logic [5:0]     f_from;
    logic           f_found;
    logic [4:0]     f_idx;

    logic [15:0]    lim;
    logic           disk_full;
    logic [WIW-1:0] ws;
    logic [SIW-1:0] cur_s;
    logic [WIW+4:0] blk_full;
    logic [31:0]    sweep_word;
    logic [31:0]    acc_new;
    logic [31:0]    free_left;
    logic [31:0]    sum_left;
    logic [WIW-1:0] req_w, reg_w, prev_w;
    logic           req_in_range, reg_in_range, link_ok;
    logic [31:0]    fresh_w;
    logic [31:0]    free_w;

    fba_find u_find (
        .vec   (f_vec),
        .from  (f_from),
        .found (f_found),
        .idx   (f_idx)
    );

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_wa] <= bm_wd;
        end
        bm_rd_reg <= bm_mem[bm_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sm_we)
        begin
            sm_mem[sm_wa] <= sm_wd;
        end
        sm_rd_reg <= sm_mem[sm_ra];
    end

    always_ff @(posedge clk)
    begin
        if (nt_we)
        begin
            nt_mem[nt_wa] <= nt_wd;
        end
        nt_rd_reg <= nt_mem[nt_ra];
    end

    assign lim          = (32'(reserved) < BLK_COUNT) ? reserved : 16'(BLK_COUNT);
    assign disk_full    = (32'(lim) >= BLK_COUNT);
    assign ws           = WIW'(lim >> 5);
    assign cur_s        = SIW'(cur_w_reg >> 5);
    assign blk_full     = {cur_w_reg, gb_reg};
    assign req_w        = WIW'(req.block_index >> 5);
    assign reg_w        = WIW'(req_reg.block_index >> 5);
    assign prev_w       = WIW'(req_reg.prev_block >> 5);
    assign req_in_range = (32'(req.block_index) < BLK_COUNT);
    assign reg_in_range = (32'(req_reg.block_index) < BLK_COUNT);
    assign link_ok      = req_reg.has_prev && (32'(req_reg.prev_block) < BLK_COUNT);
    assign fresh_w      = bm_rd_reg[63:32];
    assign free_w       = word_reg[31:0];
    assign free_left    = free_w & ~(32'd1 << gb_reg);
    assign sum_left     = (free_left == 32'd0) ? (sum_reg & ~(32'd1 << 5'(cur_w_reg))) : sum_reg;

    // free flags of one bitmap word during a format or clearing pass
    always_comb
    begin
        if (32'(cnt_reg) > 32'(fmt_lim_reg[15:5]))
        begin
            sweep_word = 32'hFFFF_FFFF;
        end
        else if (32'(cnt_reg) == 32'(fmt_lim_reg[15:5]))
        begin
            sweep_word = 32'hFFFF_FFFF << fmt_lim_reg[4:0];
        end
        else
        begin
            sweep_word = 32'd0;
        end
        if (cnt_reg == LAST_W)
        begin
            sweep_word = sweep_word & LAST_MASK;
        end
        acc_new = acc_reg | (32'(|sweep_word) << 5'(cnt_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fba_pkg::ST_SWEEP;
            cnt_reg     <= '0;
            acc_reg     <= '0;
            fmt_lim_reg <= LIM_RESET;
            fmt_req_reg <= 1'b0;
            top_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            acc_reg     <= acc_next;
            fmt_lim_reg <= fmt_lim_next;
            fmt_req_reg <= fmt_req_next;
            top_reg     <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        cur_w_reg <= cur_w_next;
        gb_reg    <= gb_next;
        word_reg  <= word_next;
        sum_reg   <= sum_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        fmt_lim_next = fmt_lim_reg;
        fmt_req_next = fmt_req_reg;
        req_next     = req_reg;
        cur_w_next   = cur_w_reg;
        gb_next      = gb_reg;
        word_next    = word_reg;
        sum_next     = sum_reg;
        top_next     = top_reg;

        bm_we  = 1'b0;
        bm_wa  = cur_w_reg;
        bm_wd  = word_reg;
        bm_ra  = cur_w_reg;
        sm_we  = 1'b0;
        sm_wa  = cur_s;
        sm_wd  = sum_reg;
        sm_ra  = cur_s;
        nt_we  = 1'b0;
        nt_wa  = IW'(blk_full);
        nt_wd  = fba_pkg::END_MARK;
        nt_ra  = IW'(req.block_index);
        f_vec  = bm_rd_reg[31:0];
        f_from = 6'd0;

        stat.busy = (state_reg != fba_pkg::ST_IDLE);
        stat.done = 1'b0;
        rsp       = '0;

        case (state_reg)
            fba_pkg::ST_SWEEP:
            begin
                bm_we = 1'b1;
                bm_wa = cnt_reg;
                bm_wd = {32'd0, sweep_word};
                if ((5'(cnt_reg) == 5'd31) || (cnt_reg == LAST_W))
                begin
                    sm_we           = 1'b1;
                    sm_wa           = SIW'(cnt_reg >> 5);
                    sm_wd           = acc_new;
                    top_next[sm_wa] = |acc_new;
                    acc_next        = '0;
                end
                else
                begin
                    acc_next = acc_new;
                end
                if (cnt_reg == LAST_W)
                begin
                    cnt_next     = '0;
                    fmt_req_next = 1'b0;
                    stat.done    = fmt_req_reg;
                    state_next   = fba_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            fba_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    case (req.kind)
                        fba_pkg::KIND_FORMAT:
                        begin
                            fmt_lim_next = lim;
                            fmt_req_next = 1'b1;
                            cnt_next     = '0;
                            acc_next     = '0;
                            state_next   = fba_pkg::ST_SWEEP;
                        end
                        fba_pkg::KIND_ALLOC:
                        begin
                            if (disk_full)
                            begin
                                stat.done  = 1'b1;
                                rsp.status = 1'b1;
                            end
                            else
                            begin
                                cur_w_next = ws;
                                bm_ra      = ws;
                                sm_ra      = SIW'(ws >> 5);
                                state_next = fba_pkg::ST_AL_FIRST;
                            end
                        end
                        fba_pkg::KIND_FREE:
                        begin
                            if (req_in_range)
                            begin
                                bm_ra      = req_w;
                                sm_ra      = SIW'(req_w >> 5);
                                state_next = fba_pkg::ST_FREE_WR;
                            end
                            else
                            begin
                                stat.done = 1'b1;
                            end
                        end
                        fba_pkg::KIND_READ:
                        begin
                            if (req_in_range)
                            begin
                                bm_ra      = req_w;
                                state_next = fba_pkg::ST_RD_DATA;
                            end
                            else
                            begin
                                stat.done = 1'b1;
                            end
                        end
                        default:
                        begin
                            stat.done = 1'b1;
                        end
                    endcase
                end
            end

            fba_pkg::ST_RD_DATA:
            begin
                // entries not written since the last format read as their format value
                if (fresh_w[req_reg.block_index[4:0]])
                begin
                    rsp.next_entry = nt_rd_reg;
                end
                else if (16'(req_reg.block_index) < fmt_lim_reg)
                begin
                    rsp.next_entry = fba_pkg::END_MARK;
                end
                stat.done  = 1'b1;
                state_next = fba_pkg::ST_IDLE;
            end

            fba_pkg::ST_FREE_WR:
            begin
                bm_we           = reg_in_range;
                bm_wa           = reg_w;
                bm_wd           = bm_rd_reg | {2{32'd1 << req_reg.block_index[4:0]}};
                nt_we           = reg_in_range;
                nt_wa           = IW'(req_reg.block_index);
                nt_wd           = 16'd0;
                sm_we           = reg_in_range;
                sm_wa           = SIW'(reg_w >> 5);
                sm_wd           = sm_rd_reg | (32'd1 << 5'(reg_w));
                top_next[sm_wa] = 1'b1;
                stat.done       = 1'b1;
                state_next      = fba_pkg::ST_IDLE;
            end

            fba_pkg::ST_AL_FIRST:
            begin
                f_vec    = bm_rd_reg[31:0];
                f_from   = {1'b0, lim[4:0]};
                sum_next = sm_rd_reg;
                if (f_found)
                begin
                    gb_next    = f_idx;
                    word_next  = bm_rd_reg;
                    state_next = fba_pkg::ST_AL_GRANT;
                end
                else
                begin
                    state_next = fba_pkg::ST_AL_SUMSCAN;
                end
            end

            fba_pkg::ST_AL_SUMSCAN:
            begin
                f_vec  = sum_reg;
                f_from = 6'(5'(cur_w_reg)) + 6'd1;
                if (f_found)
                begin
                    cur_w_next = WIW'({cur_s, f_idx});
                    bm_ra      = WIW'({cur_s, f_idx});
                    state_next = fba_pkg::ST_AL_WORD;
                end
                else
                begin
                    state_next = fba_pkg::ST_AL_TOPSCAN;
                end
            end

            fba_pkg::ST_AL_TOPSCAN:
            begin
                f_vec  = 32'(top_reg);
                f_from = 6'(cur_s) + 6'd1;
                if (f_found)
                begin
                    cur_w_next = WIW'({SIW'(f_idx), 5'd0});
                    sm_ra      = SIW'(f_idx);
                    state_next = fba_pkg::ST_AL_SUMRD;
                end
                else
                begin
                    stat.done  = 1'b1;
                    rsp.status = 1'b1;
                    state_next = fba_pkg::ST_IDLE;
                end
            end

            fba_pkg::ST_AL_SUMRD:
            begin
                f_vec      = sm_rd_reg;
                sum_next   = sm_rd_reg;
                cur_w_next = WIW'({cur_s, f_idx});
                bm_ra      = WIW'({cur_s, f_idx});
                state_next = fba_pkg::ST_AL_WORD;
            end

            fba_pkg::ST_AL_WORD:
            begin
                f_vec      = bm_rd_reg[31:0];
                gb_next    = f_idx;
                word_next  = bm_rd_reg;
                state_next = fba_pkg::ST_AL_GRANT;
            end

            fba_pkg::ST_AL_GRANT:
            begin
                bm_we           = 1'b1;
                bm_wd           = {word_reg[63:32] | (32'd1 << gb_reg), free_left};
                nt_we           = 1'b1;
                sm_we           = 1'b1;
                sm_wd           = sum_left;
                top_next[cur_s] = |sum_left;
                if (link_ok)
                begin
                    state_next = fba_pkg::ST_AL_LINKRD;
                end
                else
                begin
                    stat.done         = 1'b1;
                    rsp.granted_block = 15'(blk_full);
                    state_next        = fba_pkg::ST_IDLE;
                end
            end

            fba_pkg::ST_AL_LINKRD:
            begin
                // read after the grant write so a shared word sees the new flags
                bm_ra      = prev_w;
                state_next = fba_pkg::ST_AL_LINKWR;
            end

            fba_pkg::ST_AL_LINKWR:
            begin
                bm_we             = 1'b1;
                bm_wa             = prev_w;
                bm_wd             = bm_rd_reg | {32'd1 << req_reg.prev_block[4:0], 32'd0};
                nt_we             = 1'b1;
                nt_wa             = IW'(req_reg.prev_block);
                nt_wd             = 16'(blk_full);
                stat.done         = 1'b1;
                rsp.granted_block = 15'(blk_full);
                state_next        = fba_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = fba_pkg::ST_IDLE;
            end
        endcase
    end

    // an accepted beat that does not finish at once keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !stat.busy && !stat.done) |=> stat.busy)
        else $error("accepted request did not start work");

    // summary said this group holds a free word
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fba_pkg::ST_AL_SUMRD) |-> (sm_rd_reg != 32'd0))
        else $error("summary group marked but empty");

    // summary said this word holds a free block
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fba_pkg::ST_AL_WORD) |-> (bm_rd_reg[31:0] != 32'd0))
        else $error("summary word bit set but bitmap word empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fba_pkg::ST_AL_GRANT) |-> (free_w[gb_reg] && (32'(blk_full) < BLK_COUNT)))
        else $error("granting a block that is not free");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fba_pkg::ST_AL_GRANT) |-> (32'(blk_full) >= 32'(lim)))
        else $error("granting a reserved block");

endmodule

`default_nettype wire

FILE: src/fat_block_allocator_unit.sv
// Top level of the block allocator: reserved-count register and result register.
// Depends on fba_pkg and fba_core.
`default_nettype none

// Allocator for a disk of NUM_BLOCKS blocks (at most 32768 are used) with a free
// bitmap and a next-block table. A request is taken when start is high and busy
// is low; its single result appears on rsp with done high for exactly one cycle,
// registered in the cycle after the request finishes, and must be captured then
// since there is no back-pressure. A new request can be taken in the cycle its
// result shows. An allocate walks a chain of bitmap, summary and top-level
// lookups through one shared find-first unit, with a further bitmap read and
// write for the previous block when one is linked; a full disk with everything
// reserved and an out-of-range free or read finish at once; format writes one
// bitmap word per cycle. After reset a clearing pass runs with busy high;
// writes to reserved_blocks (cfg_we/cfg_wdata) belong between requests, while
// busy is low and no result is pending, and apply to later allocate and format
// requests only.
module fat_block_allocator_unit #(
    parameter int NUM_BLOCKS = fba_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire fba_pkg::fba_req_t         req,
    output logic                           done,
    output fba_pkg::fba_rsp_t              rsp,
    input  wire logic                      cfg_we,
    input  wire logic [fba_pkg::CFG_W-1:0] cfg_wdata
);

    logic [fba_pkg::CFG_W-1:0] reserved_reg;
    logic                      done_reg;
    fba_pkg::fba_rsp_t         rsp_reg;
    fba_pkg::fba_stat_t        core_stat;
    fba_pkg::fba_rsp_t         core_rsp;

    fba_core #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .reserved (reserved_reg),
        .stat     (core_stat),
        .rsp      (core_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= fba_pkg::RESERVED_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                reserved_reg <= cfg_wdata;
            end
            done_reg <= core_stat.done;
        end
    end

    // result captured when the core finishes; done marks it for one cycle
    always_ff @(posedge clk)
    begin
        if (core_stat.done)
        begin
            rsp_reg <= core_rsp;
        end
    end

    assign busy = core_stat.busy;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire
